[rtl/histogram_bisection_binning_unit_defines.svh]
// Assertion helpers for the binning unit checker.
`ifndef HISTOGRAM_BISECTION_BINNING_UNIT_DEFINES_SVH
`define HISTOGRAM_BISECTION_BINNING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HBBU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hbbu check failed");

// Next-cycle implication, disabled while reset is low.
`define HBBU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hbbu check failed");

`endif

[rtl/hbbu_pkg.sv]
`timescale 1ns / 1ps

package hbbu_pkg;

    localparam int NUM_BINS    = 64;
    localparam int IDX_W       = 6;
    localparam int COUNT_W     = 32;
    localparam int THR_W       = 32;
    localparam int STACK_DEPTH = 7;
    localparam int SP_W        = 3;

    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(2000);

    localparam logic [REG_IDX_W-1:0] REG_SPLIT_THRESHOLD = REG_IDX_W'(0);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
    } bin_range_t;

endpackage

[rtl/histogram_bisection_binning_unit.sv]
// Histogram rebinning by bisection. A load item (s_cmd = 0) writes one bin count into
// the 64-entry bin store; the store reads as zero after reset. A run item (s_cmd = 1)
// walks the range [s_range_first, s_range_last] depth first, splitting at the floor
// midpoint when the range holds more than one bin, the stack has room and both halves
// each sum (saturating) to at least split_threshold, and returns one result item per
// unsplit leaf, left to right, with m_is_final_leaf on the last. A reversed range
// returns a single leaf flagged bad. s_ready is low for the whole run. Sums are formed
// by one saturating adder fed from the single read port of the bin store, one bin per
// cycle, and each leaf may wait on m_ready. Results sit in an output register, so a
// finished leaf may wait while the next item is taken in.
`timescale 1ns / 1ps

module histogram_bisection_binning_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hbbu_pkg::PADDR_W-1:0]    paddr,
    input  logic [hbbu_pkg::DATA_W-1:0]     pwdata,
    output logic [hbbu_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [hbbu_pkg::IDX_W-1:0]      s_bin_index,
    input  logic [hbbu_pkg::COUNT_W-1:0]    s_bin_count,
    input  logic [hbbu_pkg::IDX_W-1:0]      s_range_first,
    input  logic [hbbu_pkg::IDX_W-1:0]      s_range_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hbbu_pkg::IDX_W-1:0]      m_leaf_first,
    output logic [hbbu_pkg::IDX_W-1:0]      m_leaf_last,
    output logic                            m_is_final_leaf,
    output logic                            m_bad_range
);
    import hbbu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUM_L,
        ST_WAIT_L,
        ST_SUM_R,
        ST_WAIT_R,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [IDX_W-1:0]     a_reg;
    logic [IDX_W-1:0]     b_reg;
    logic [IDX_W-1:0]     mid_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SP_W-1:0]      sp_reg;
    logic [COUNT_W-1:0]   acc_reg;
    logic                 left_ok_reg;
    logic                 bad_reg;
    logic                 rd_vld_reg;

    logic                 m_valid_reg;
    logic [IDX_W-1:0]     m_first_reg;
    logic [IDX_W-1:0]     m_last_reg;
    logic                 m_final_reg;
    logic                 m_bad_reg;

    logic [COUNT_W-1:0]   bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0]  bin_vld_reg;
    logic [COUNT_W-1:0]   rd_data_reg;
    logic                 rd_hit_reg;

    bin_range_t           stack_mem [STACK_DEPTH];
    bin_range_t           top_entry;

    logic                 s_accept;
    logic                 load_wr;
    logic                 cfg_wr;
    logic                 rd_en;
    logic                 push;
    logic                 out_free;
    logic [IDX_W:0]       mid_sum;
    logic [IDX_W-1:0]     mid;
    logic [COUNT_W-1:0]   rd_word;
    logic [COUNT_W:0]     sum_wide;
    logic [COUNT_W-1:0]   acc_add;
    logic                 half_ok;
    logic [SP_W-1:0]      sp_dec;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[PADDR_W-1:2] == REG_SPLIT_THRESHOLD);
    assign prdata   = (paddr[PADDR_W-1:2] == REG_SPLIT_THRESHOLD) ? thr_reg : '0;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign load_wr  = s_accept && (s_cmd == CMD_LOAD);

    assign mid_sum  = {1'b0, a_reg} + {1'b0, b_reg};
    assign mid      = mid_sum[IDX_W:1];

    assign rd_en    = (state_reg == ST_SUM_L) || (state_reg == ST_SUM_R);

    // never-written bins read as zero
    assign rd_word  = rd_hit_reg ? rd_data_reg : '0;
    assign sum_wide = {1'b0, acc_reg} + {1'b0, rd_word};
    assign acc_add  = sum_wide[COUNT_W] ? '1 : sum_wide[COUNT_W-1:0];
    assign half_ok  = (acc_add >= thr_reg);

    assign push     = (state_reg == ST_WAIT_R) && left_ok_reg && half_ok;
    assign out_free = !m_valid_reg || m_ready;
    assign sp_dec   = sp_reg - SP_W'(1);
    assign top_entry = stack_mem[sp_dec];

    assign m_valid         = m_valid_reg;
    assign m_leaf_first    = m_first_reg;
    assign m_leaf_last     = m_last_reg;
    assign m_is_final_leaf = m_final_reg;
    assign m_bad_range     = m_bad_reg;

    always_ff @(posedge aclk) begin
        if (load_wr) begin
            bin_mem[s_bin_index] <= s_bin_count;
        end
        if (rd_en) begin
            rd_data_reg <= bin_mem[idx_reg];
            rd_hit_reg  <= bin_vld_reg[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
        end else if (load_wr) begin
            bin_vld_reg[s_bin_index] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[sp_reg] <= '{first: IDX_W'(mid_reg + IDX_W'(1)), last: b_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= THRESHOLD_RESET;
            sp_reg      <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            // a leaf loaded this cycle keeps the output valid
            if (m_valid_reg && m_ready && !((state_reg == ST_EMIT) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                thr_reg <= pwdata;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_cmd == CMD_RUN)) begin
                        a_reg  <= s_range_first;
                        b_reg  <= s_range_last;
                        sp_reg <= '0;
                        if (s_range_first > s_range_last) begin
                            bad_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else begin
                            bad_reg   <= 1'b0;
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                ST_EVAL: begin
                    if ((a_reg < b_reg) && (sp_reg < SP_W'(STACK_DEPTH))) begin
                        mid_reg   <= mid;
                        idx_reg   <= a_reg;
                        acc_reg   <= '0;
                        state_reg <= ST_SUM_L;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_SUM_L: begin
                    if (rd_vld_reg) begin
                        acc_reg <= acc_add;
                    end
                    if (idx_reg == mid_reg) begin
                        state_reg <= ST_WAIT_L;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_WAIT_L: begin
                    // last left bin lands this cycle
                    left_ok_reg <= half_ok;
                    acc_reg     <= '0;
                    idx_reg     <= mid_reg + IDX_W'(1);
                    state_reg   <= ST_SUM_R;
                end
                ST_SUM_R: begin
                    if (rd_vld_reg) begin
                        acc_reg <= acc_add;
                    end
                    if (idx_reg == b_reg) begin
                        state_reg <= ST_WAIT_R;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_WAIT_R: begin
                    if (push) begin
                        sp_reg    <= sp_reg + SP_W'(1);
                        b_reg     <= mid_reg;
                        state_reg <= ST_EVAL;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_first_reg <= a_reg;
                        m_last_reg  <= b_reg;
                        m_final_reg <= (sp_reg == '0);
                        m_bad_reg   <= bad_reg;
                        if (sp_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            sp_reg    <= sp_dec;
                            a_reg     <= top_entry.first;
                            b_reg     <= top_entry.last;
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/hbbu_checker.sv]
`timescale 1ns / 1ps
`include "histogram_bisection_binning_unit_defines.svh"

module hbbu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_cmd,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [hbbu_pkg::IDX_W-1:0]      m_leaf_first,
    input logic [hbbu_pkg::IDX_W-1:0]      m_leaf_last,
    input logic                            m_is_final_leaf,
    input logic                            m_bad_range
);
    import hbbu_pkg::*;

    // a stalled result item holds
    `HBBU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_leaf_first, m_leaf_last, m_is_final_leaf, m_bad_range}))

    // a reversed range is always the only, and so the final, leaf
    `HBBU_ASSERT_SAME(a_bad_final, aclk, aresetn, m_valid && m_bad_range, m_is_final_leaf && (m_leaf_first > m_leaf_last))

    // a good leaf is an ordered range
    `HBBU_ASSERT_SAME(a_leaf_order, aclk, aresetn, m_valid && !m_bad_range, m_leaf_first <= m_leaf_last)

    // a run keeps the input side closed while it walks
    `HBBU_ASSERT_NEXT(a_run_busy, aclk, aresetn, s_valid && s_ready && (s_cmd == CMD_RUN), !s_ready)

    // a load leaves the input side open
    `HBBU_ASSERT_NEXT(a_load_quick, aclk, aresetn, s_valid && s_ready && (s_cmd == CMD_LOAD), s_ready)

endmodule

bind histogram_bisection_binning_unit hbbu_checker u_hbbu_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_cmd           (s_cmd),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_leaf_first    (m_leaf_first),
    .m_leaf_last     (m_leaf_last),
    .m_is_final_leaf (m_is_final_leaf),
    .m_bad_range     (m_bad_range)
);

[tb/tb_histogram_bisection_binning_unit.sv]
`timescale 1ns / 1ps

module tb_histogram_bisection_binning_unit;

    import hbbu_pkg::*;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned SQUEEZE_CYCLES = 400;
    localparam logic [PADDR_W-1:0] THR_ADDR = {REG_SPLIT_THRESHOLD, 2'b00};

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   index;
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   first;
        logic [IDX_W-1:0]   last;
    } bin_cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        logic             final_flag;
        logic             bad;
    } leaf_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_cmd = CMD_LOAD;
    logic [IDX_W-1:0]     s_bin_index = '0;
    logic [COUNT_W-1:0]   s_bin_count = '0;
    logic [IDX_W-1:0]     s_range_first = '0;
    logic [IDX_W-1:0]     s_range_last = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IDX_W-1:0]     m_leaf_first;
    logic [IDX_W-1:0]     m_leaf_last;
    logic                 m_is_final_leaf;
    logic                 m_bad_range;

    // predictor state
    logic [COUNT_W-1:0]   bin_counts [NUM_BINS];
    logic [THR_W-1:0]     split_thr = THRESHOLD_RESET;

    bin_cmd_t             pending [$];
    leaf_t                leaves_due [$];
    int unsigned          items_queued = 0;
    int unsigned          items_sent = 0;
    int unsigned          mismatches = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          tx_gap = 0;
    int unsigned          rx_wait = 0;
    int unsigned          hold_asks = 0;
    int unsigned          hold_done = 0;
    bit                   gaps_on = 1'b1;
    logic                 in_taken = 1'b0;
    logic                 out_taken = 1'b0;

    histogram_bisection_binning_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_bin_index     (s_bin_index),
        .s_bin_count     (s_bin_count),
        .s_range_first   (s_range_first),
        .s_range_last    (s_range_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_leaf_first    (m_leaf_first),
        .m_leaf_last     (m_leaf_last),
        .m_is_final_leaf (m_is_final_leaf),
        .m_bad_range     (m_bad_range)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < NUM_BINS; i++) bin_counts[i] = '0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void diff_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // saturating sum over an inclusive bin span
    function automatic logic [COUNT_W-1:0] span_total(input int lo, input int hi);
        logic [COUNT_W:0] acc;
        acc = '0;
        for (int i = lo; i <= hi; i++) begin
            acc = acc + {1'b0, bin_counts[i]};
            if (acc[COUNT_W]) acc = {1'b0, {COUNT_W{1'b1}}};
        end
        return acc[COUNT_W-1:0];
    endfunction

    // depth-first bisection, right halves parked on a stack
    function automatic void apply_item(input bin_cmd_t it);
        int lo, hi, mid, depth;
        int park_lo [STACK_DEPTH];
        int park_hi [STACK_DEPTH];
        bit done;
        if (it.cmd == CMD_LOAD) begin
            bin_counts[it.index] = it.count;
            return;
        end
        lo = int'(it.first);
        hi = int'(it.last);
        if (lo > hi) begin
            leaves_due.insert(leaves_due.size(), leaf_t'{it.first, it.last, 1'b1, 1'b1});
            return;
        end
        depth = 0;
        done = 1'b0;
        while (!done) begin
            mid = (lo + hi) / 2;
            if (lo < hi && depth < STACK_DEPTH && span_total(lo, mid) >= split_thr
                    && span_total(mid + 1, hi) >= split_thr) begin
                park_lo[depth] = mid + 1;
                park_hi[depth] = hi;
                depth++;
                hi = mid;
            end else begin
                leaves_due.insert(leaves_due.size(),
                                  leaf_t'{IDX_W'(lo), IDX_W'(hi), 1'b0, 1'b0});
                if (depth == 0) begin
                    done = 1'b1;
                end else begin
                    depth--;
                    lo = park_lo[depth];
                    hi = park_hi[depth];
                end
            end
        end
        leaves_due[leaves_due.size() - 1].final_flag = 1'b1;
    endfunction

    function automatic void check_leaf();
        leaf_t want;
        if (leaves_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: unexpected leaf %0d..%0d, expected none", $time,
                         m_leaf_first, m_leaf_last);
            return;
        end
        want = leaves_due.pop_front();
        diff_field("leaf_first", 32'(want.first), 32'(m_leaf_first));
        diff_field("leaf_last", 32'(want.last), 32'(m_leaf_last));
        diff_field("is_final_leaf", 32'(want.final_flag), 32'(m_is_final_leaf));
        diff_field("bad_range", 32'(want.bad), 32'(m_bad_range));
    endfunction

    // sampling, prediction, checking and watchdog
    always @(posedge aclk) begin
        in_taken  <= s_valid && s_ready;
        out_taken <= m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            apply_item('{s_cmd, s_bin_index, s_bin_count, s_range_first, s_range_last});
            items_sent++;
        end
        if (aresetn && m_valid && m_ready) check_leaf();
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // sender
    always @(negedge aclk) begin : feed
        bit keep;
        bin_cmd_t nxt;
        keep = s_valid && !in_taken;
        if (!aresetn) begin
            keep = 1'b0;
        end else if (!keep) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending.size() != 0) begin
                nxt = pending.pop_front();
                s_cmd         <= nxt.cmd;
                s_bin_index   <= nxt.index;
                s_bin_count   <= nxt.count;
                s_range_first <= nxt.first;
                s_range_last  <= nxt.last;
                keep = 1'b1;
                tx_gap = pick_gap();
            end
        end
        s_valid <= keep;
    end

    // receiver; a requested hold-off keeps ready low long enough to back up the input
    always @(negedge aclk) begin : drain
        bit rdy;
        if (hold_asks != hold_done) begin
            rx_wait = SQUEEZE_CYCLES;
            hold_done++;
        end else if (out_taken) begin
            rx_wait = pick_gap();
        end
        if (rx_wait > 0) begin
            rdy = 1'b0;
            rx_wait--;
        end else begin
            rdy = 1'b1;
        end
        m_ready <= rdy;
    end

    task automatic apb_rw(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= THR_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_threshold(input logic [31:0] value);
        logic [31:0] back;
        apb_rw(1'b1, value, back);
        split_thr = value;
        apb_rw(1'b0, '0, back);
        diff_field("split_threshold readback", value, back);
    endtask

    function automatic void queue_load(input int unsigned idx, input logic [31:0] cnt);
        bin_cmd_t it;
        it.cmd   = CMD_LOAD;
        it.index = IDX_W'(idx);
        it.count = cnt;
        it.first = IDX_W'($urandom());
        it.last  = IDX_W'($urandom());
        pending.insert(pending.size(), it);
        items_queued++;
    endfunction

    function automatic void queue_run(input int unsigned f, input int unsigned l);
        bin_cmd_t it;
        it.cmd   = CMD_RUN;
        it.index = IDX_W'($urandom());
        it.count = $urandom();
        it.first = IDX_W'(f);
        it.last  = IDX_W'(l);
        pending.insert(pending.size(), it);
        items_queued++;
    endfunction

    function automatic void queue_random_load(input logic [31:0] scale);
        int unsigned r;
        logic [31:0] cnt;
        r = $urandom_range(0, 99);
        if (r < 10) cnt = '0;
        else if (r < 18) cnt = $urandom();
        else if (r < 24) cnt = '1;
        else cnt = $urandom_range(0, scale);
        queue_load($urandom_range(0, NUM_BINS - 1), cnt);
    endfunction

    // mostly narrow spans; wide ones are slow to walk
    function automatic void queue_random_run();
        int unsigned r, f, w;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            f = $urandom_range(1, 63);
            queue_run(f, $urandom_range(0, f - 1));
        end else begin
            if (r < 70) w = $urandom_range(0, 15);
            else if (r < 93) w = $urandom_range(16, 47);
            else w = $urandom_range(48, 63);
            f = $urandom_range(0, 63 - w);
            queue_run(f, f + w);
        end
    endfunction

    // wait for every item to be taken and every leaf returned, then add a quiet margin
    task automatic settle();
        while (items_sent != items_queued || leaves_due.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic random_phase(input logic [31:0] thr, input int n, input logic [31:0] scale,
                                input bit idle, input bit squeeze);
        set_threshold(thr);
        gaps_on = idle;
        for (int k = 0; k < n; k++) begin
            if (k < 6 || $urandom_range(0, 99) < 35) queue_random_load(scale);
            else queue_random_run();
        end
        if (squeeze) hold_asks++;
        settle();
    endtask

    initial begin
        logic [31:0] back;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apb_rw(1'b0, '0, back);
        diff_field("split_threshold after reset", THRESHOLD_RESET, back);

        // empty store, then saturating halves, reversed and one-bin spans
        queue_run(0, 63);
        queue_load(0, 32'hFFFF_FFFF);
        queue_load(63, 32'hFFFF_FFFF);
        queue_load(31, 32'h0);
        queue_load(32, 32'd1999);
        queue_load(10, 32'h8000_0000);
        queue_run(0, 63);
        queue_run(63, 0);
        queue_run(1, 0);
        queue_run(7, 7);
        queue_run(63, 63);
        queue_run(0, 1);
        queue_load(1, 32'd2000);
        queue_run(0, 1);
        settle();

        // zero threshold splits down to single bins
        set_threshold(32'h0);
        queue_run(0, 63);
        queue_run(20, 23);
        queue_run(40, 40);
        settle();

        set_threshold(32'hFFFF_FFFF);
        queue_load(2, 32'hFFFF_FFFF);
        queue_load(3, 32'd1);
        queue_run(0, 3);
        queue_run(0, 62);
        settle();

        random_phase($urandom_range(200, 4000), 40, 32'd0, 1'b1, 1'b0);
        random_phase(32'h0, 30, 32'd1000, 1'b0, 1'b0);
        random_phase($urandom_range(1000, 100000), 45, 32'd0, 1'b1, 1'b1);
        random_phase(32'hFFFF_FFFF, 35, 32'hFFFF_FFFF, 1'b1, 1'b0);
        random_phase(32'd1, 40, 32'd2, 1'b1, 1'b0);

        if (mismatches == 0 && leaves_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/hbbu_pkg.sv
rtl/histogram_bisection_binning_unit.sv
rtl/hbbu_checker.sv
tb/tb_histogram_bisection_binning_unit.sv
